@@ rtl/core/assert_macros.svh @@
// shared assertion macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only outside reset
`define ASSERT_CLK(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked at every edge, reset included
`define ASSERT_ALL(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

@@ rtl/core/iac_pkg.sv @@
package iac_pkg;

   localparam int unsigned CountWidth = 32;
   localparam int unsigned CsrDataWidth = 32;
   localparam int unsigned CsrIndexWidth = 1;

   localparam logic [1:0] ModeDisabled = 2'd0;
   localparam logic [1:0] ModeArming = 2'd1;
   localparam logic [1:0] ModeListening = 2'd2;

   localparam logic [CsrIndexWidth-1:0] CsrListenDelay = 1'd0;
   localparam logic [CsrIndexWidth-1:0] CsrAlertDelay = 1'd1;

   localparam logic [CountWidth-1:0] ListenDelayReset = 32'd60000;
   localparam logic [CountWidth-1:0] AlertDelayReset = 32'd10000;

   typedef struct packed {
      logic func;
      logic listen_request;
      logic motion_level;
      logic key_switch_level;
   } req_type;

   typedef struct packed {
      logic [1:0] arm_mode;
      logic buzzer_on;
      logic start_buzzer_on;
      logic listening_lamp;
      logic idle_lamp;
      logic breach_flag;
   } rsp_type;

   typedef struct packed {
      logic [CountWidth-1:0] listen_delay_ms;
      logic [CountWidth-1:0] alert_delay_ms;
   } cfg_type;

endpackage

@@ rtl/core/intrusion_alarm_controller.sv @@
// an accepted request is held in the input register, then its response is loaded into the response register
// throughput: one request per cycle, sustained with no stall on the response side
// the input register and the response register each hold one request, so the
// block takes a new request while a finished response waits to be taken
// reset: synchronous active high; alarm disabled, counters cleared, delays at defaults
module intrusion_alarm_controller (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  iac_pkg::req_type req_payload,
   output logic rsp_valid,
   input  logic rsp_stall,
   output iac_pkg::rsp_type rsp_payload,
   input  logic csr_write_enable,
   input  logic [iac_pkg::CsrIndexWidth-1:0] csr_index,
   input  logic [iac_pkg::CsrDataWidth-1:0] csr_write_data
);
   import iac_pkg::*;

   `include "assert_macros.svh"

   logic s1_valid_ff;
   req_type s1_req_ff;
   logic rsp_valid_ff;
   rsp_type rsp_ff;
   logic advance;
   cfg_type cfg;
   rsp_type core_rsp;

   assign advance = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && !advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (!req_stall) begin
            s1_valid_ff <= req_valid;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         s1_req_ff <= req_payload;
      end
      if (advance) begin
         rsp_ff <= core_rsp;
      end
   end

   iac_csr u_csr (
      .clock(clock),
      .reset(reset),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_write_data(csr_write_data),
      .cfg(cfg)
   );

   iac_core u_core (
      .clock(clock),
      .reset(reset),
      .step(advance),
      .req(s1_req_ff),
      .cfg(cfg),
      .rsp(core_rsp)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   `ASSERT_CLK(a_advance_fills_rsp, advance |=> rsp_valid_ff, "response register not loaded")
   `ASSERT_CLK(a_stall_keeps_s1, req_stall |=> s1_valid_ff, "held request dropped")
   `ASSERT_ALL(a_reset_clears, reset |=> !rsp_valid_ff && !s1_valid_ff, "reset left a request")

endmodule

@@ rtl/core/iac_csr.sv @@
module iac_csr (
   input  logic clock,
   input  logic reset,
   input  logic csr_write_enable,
   input  logic [iac_pkg::CsrIndexWidth-1:0] csr_index,
   input  logic [iac_pkg::CsrDataWidth-1:0] csr_write_data,
   output iac_pkg::cfg_type cfg
);
   import iac_pkg::*;

   cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.listen_delay_ms <= ListenDelayReset;
         cfg_ff.alert_delay_ms <= AlertDelayReset;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CsrListenDelay: cfg_ff.listen_delay_ms <= csr_write_data;
            CsrAlertDelay: cfg_ff.alert_delay_ms <= csr_write_data;
            default: ;
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ rtl/core/iac_core.sv @@
module iac_core (
   input  logic clock,
   input  logic reset,
   input  logic step,
   input  iac_pkg::req_type req,
   input  iac_pkg::cfg_type cfg,
   output iac_pkg::rsp_type rsp
);
   import iac_pkg::*;

   `include "assert_macros.svh"

   logic [1:0] mode_ff, mode_in;
   logic [CountWidth-1:0] uptime_ff, uptime_in;
   logic [CountWidth-1:0] arming_ff, arming_in;
   logic [CountWidth-1:0] motion_cnt_ff, motion_cnt_in;
   logic pending_ff, pending_in;
   logic breach_ff, breach_in;
   logic warn_en_ff, warn_en_in;
   logic last_key_ff, last_key_in;
   logic key_known_ff, key_known_in;
   logic buzz_ff, buzz_in;
   logic warn_pin_ff, warn_pin_in;
   logic listen_lamp_ff, listen_lamp_in;
   logic idle_lamp_ff, idle_lamp_in;

   function automatic logic [CountWidth-1:0] sat_inc(input logic [CountWidth-1:0] v);
      sat_inc = (v == '1) ? v : v + 1'b1;
   endfunction

   always_comb begin
      mode_in = mode_ff;
      uptime_in = uptime_ff;
      arming_in = arming_ff;
      motion_cnt_in = motion_cnt_ff;
      pending_in = pending_ff;
      breach_in = breach_ff;
      warn_en_in = warn_en_ff;
      last_key_in = last_key_ff;
      key_known_in = key_known_ff;
      buzz_in = buzz_ff;
      warn_pin_in = warn_pin_ff;
      listen_lamp_in = listen_lamp_ff;
      idle_lamp_in = idle_lamp_ff;
      if (req.func) begin
         warn_en_in = 1'b1;
         if (!req.listen_request) begin
            mode_in = ModeDisabled;
         end else if (mode_ff == ModeDisabled) begin
            mode_in = ModeArming;
            arming_in = '0;
         end
      end else begin
         uptime_in = sat_inc(uptime_ff);
         arming_in = sat_inc(arming_ff);
         if (pending_ff) begin
            motion_cnt_in = sat_inc(motion_cnt_ff);
         end
         if (!key_known_ff) begin
            key_known_in = 1'b1;
            last_key_in = req.key_switch_level;
         end else if (req.key_switch_level != last_key_ff) begin
            warn_en_in = 1'b0;
            last_key_in = req.key_switch_level;
            if (mode_ff == ModeDisabled) begin
               mode_in = ModeArming;
               arming_in = '0;
            end else begin
               mode_in = ModeDisabled;
            end
         end
         if (mode_in == ModeArming && arming_in >= cfg.listen_delay_ms) begin
            mode_in = ModeListening;
         end
         case (mode_in)
            ModeDisabled: begin
               buzz_in = 1'b0;
               warn_pin_in = 1'b0;
               listen_lamp_in = 1'b0;
               idle_lamp_in = 1'b1;
               pending_in = 1'b0;
               motion_cnt_in = '0;
               breach_in = 1'b0;
            end
            ModeArming: begin
               buzz_in = 1'b0;
               listen_lamp_in = 1'b1;
               idle_lamp_in = 1'b1;
               if (req.motion_level && warn_en_in) begin
                  warn_pin_in = 1'b1;
               end
            end
            default: begin
               listen_lamp_in = 1'b1;
               idle_lamp_in = 1'b0;
               if (uptime_in >= cfg.listen_delay_ms) begin
                  if (!req.motion_level) begin
                     pending_in = 1'b0;
                     motion_cnt_in = '0;
                  end else if (!pending_ff) begin
                     pending_in = 1'b1;
                     motion_cnt_in = '0;
                  end else if (motion_cnt_in >= cfg.alert_delay_ms) begin
                     breach_in = 1'b1;
                     buzz_in = 1'b1;
                     warn_pin_in = 1'b1;
                  end
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= ModeDisabled;
         uptime_ff <= '0;
         arming_ff <= '0;
         motion_cnt_ff <= '0;
         pending_ff <= 1'b0;
         breach_ff <= 1'b0;
         warn_en_ff <= 1'b0;
         last_key_ff <= 1'b0;
         key_known_ff <= 1'b0;
         buzz_ff <= 1'b0;
         warn_pin_ff <= 1'b0;
         listen_lamp_ff <= 1'b0;
         idle_lamp_ff <= 1'b0;
      end else if (step) begin
         mode_ff <= mode_in;
         uptime_ff <= uptime_in;
         arming_ff <= arming_in;
         motion_cnt_ff <= motion_cnt_in;
         pending_ff <= pending_in;
         breach_ff <= breach_in;
         warn_en_ff <= warn_en_in;
         last_key_ff <= last_key_in;
         key_known_ff <= key_known_in;
         buzz_ff <= buzz_in;
         warn_pin_ff <= warn_pin_in;
         listen_lamp_ff <= listen_lamp_in;
         idle_lamp_ff <= idle_lamp_in;
      end
   end

   always_comb begin
      rsp.arm_mode = mode_in;
      rsp.buzzer_on = buzz_in;
      rsp.start_buzzer_on = warn_pin_in;
      rsp.listening_lamp = listen_lamp_in;
      rsp.idle_lamp = idle_lamp_in;
      rsp.breach_flag = breach_in;
   end

   `ASSERT_CLK(a_key_known_sticks, key_known_ff |=> key_known_ff, "key level lost")
   `ASSERT_CLK(a_cmd_sets_warn, step && req.func |=> warn_en_ff, "remote request left warning off")

endmodule
